@@ src/mkte_pkg.sv @@
package mkte_pkg;

   localparam int STAMP_BITS = 32;
   localparam int KEY_W      = 8;
   localparam int POS_W      = 8;
   localparam int MAXLEN_W   = 8;
   localparam int DELAY_W    = 16;
   localparam int TAP_W      = 3;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 10;
   localparam int MAX_TAPS   = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;
   localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;
   localparam logic [KEY_W-1:0] KEY_CLEAR = 8'h43;
   localparam logic [KEY_W-1:0] KEY_ENTER = 8'h45;

   localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RESET   = 8'd16;
   localparam logic [DELAY_W-1:0]  SWITCH_DELAY_RESET = 16'd1000;

   typedef logic [STAMP_BITS-1:0] stamp_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_WRITE  = 2'd1,
      ACT_ERASE  = 2'd2,
      ACT_FINISH = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_LENGTH   = 1'b0,
      CSR_SWITCH_DELAY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               active;
      logic [POS_W-1:0]   cursor;
      logic [TAP_W-1:0]   tap_index;
      logic [KEY_W-1:0]   prev_key;
      stamp_type          prev_time;
   } entry_state_type;

   typedef struct packed {
      action_type         action;
      logic [POS_W-1:0]   position;
      logic [KEY_W-1:0]   out_char;
      logic [POS_W-1:0]   entry_length;
   } result_type;

   typedef struct packed {
      logic [MAXLEN_W-1:0] max_length;
      logic [DELAY_W-1:0]  switch_delay;
   } config_type;

   localparam logic [KEY_W-1:0] LETTER_TAB [NUM_DIGITS][MAX_TAPS] = '{
      '{8'h20, 8'h30, 8'h00, 8'h00, 8'h00},
      '{8'h20, 8'h31, 8'h00, 8'h00, 8'h00},
      '{8'h41, 8'h42, 8'h43, 8'h32, 8'h00},
      '{8'h44, 8'h45, 8'h46, 8'h33, 8'h00},
      '{8'h47, 8'h48, 8'h49, 8'h34, 8'h00},
      '{8'h4A, 8'h4B, 8'h4C, 8'h35, 8'h00},
      '{8'h4D, 8'h4E, 8'h4F, 8'h36, 8'h00},
      '{8'h50, 8'h51, 8'h52, 8'h53, 8'h37},
      '{8'h54, 8'h55, 8'h56, 8'h38, 8'h00},
      '{8'h57, 8'h58, 8'h59, 8'h5A, 8'h39}
   };

   function automatic logic [KEY_W-1:0] letter_at(input logic [DIGIT_W-1:0] d,
                                                  input logic [TAP_W-1:0]   idx);
      logic [KEY_W-1:0] ch;
      ch = '0;
      if (d < DIGIT_W'(NUM_DIGITS) && idx < TAP_W'(MAX_TAPS)) begin
         ch = LETTER_TAB[d][idx];
      end
      return ch;
   endfunction

   function automatic logic [TAP_W-1:0] tap_count(input logic [DIGIT_W-1:0] d);
      logic [TAP_W-1:0] n;
      case (d)
         4'd0, 4'd1: n = 3'd2;
         4'd7, 4'd9: n = 3'd5;
         default:    n = 3'd4;
      endcase
      return n;
   endfunction

   // (tap + 1) mod count, count being 2, 4 or 5
   function automatic logic [TAP_W-1:0] next_tap(input logic [TAP_W-1:0] tap,
                                                 input logic [TAP_W-1:0] cnt);
      logic [TAP_W:0]   v;
      logic [TAP_W-1:0] r;
      v = {1'b0, tap} + 1'b1;
      case (cnt)
         3'd2:    r = {2'b00, v[0]};
         3'd4:    r = {1'b0, v[1:0]};
         default: r = (v < 4'd5) ? v[TAP_W-1:0] : TAP_W'(v - 4'd5);
      endcase
      return r;
   endfunction

endpackage

@@ src/mkte_ifs.sv @@
interface mkte_req_if;
   logic                                valid;
   logic                                ready;
   logic [mkte_pkg::KEY_W-1:0]          key_code;
   logic [mkte_pkg::STAMP_BITS-1:0]     press_time;

   modport source (output valid, key_code, press_time, input ready);
   modport sink   (input valid, key_code, press_time, output ready);
endinterface

interface mkte_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          action;
   logic [mkte_pkg::POS_W-1:0]          position;
   logic [mkte_pkg::KEY_W-1:0]          out_char;
   logic [mkte_pkg::POS_W-1:0]          entry_length;

   modport source (output valid, action, position, out_char, entry_length, input ready);
   modport sink   (input valid, action, position, out_char, entry_length, output ready);
endinterface

@@ src/multitap_keypad_text_entry.sv @@
// Multi-tap keypad text entry.
// req_if carries one keypress per item (key_code, press_time in ms). rsp_if
// returns exactly one item per keypress: action (none, write, erase, finish),
// position, out_char and entry_length.
// csr_we/csr_index/csr_wdata write max_length (index 0) and switch_delay
// (index 1); write them only while no keypress is in flight.
// Pipeline: an input register, then the step logic (table lookup, stamp gap
// compare, cursor update) feeding the result register. The entry state is
// updated as an item moves into the result register.
// An accepted keypress moves on to rsp_if once the result register is free.
// Throughput: one keypress per cycle while rsp_if.ready is high.
// Stalls: while rsp_if.ready is low the result holds; one more item waits in
// the input register, after which req_if.ready drops.
// Reset (synchronous, active high): both stages empty, entry waiting for its
// first key, max_length 16, switch_delay 1000.
module multitap_keypad_text_entry (
   input  logic                              clock,
   input  logic                              reset,
   mkte_req_if.sink                          req_if,
   mkte_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [mkte_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mkte_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mkte_pkg::*;

   config_type        cfg;

   logic              in_valid_ff;
   logic [KEY_W-1:0]  in_key_ff;
   stamp_type         in_time_ff;

   entry_state_type   st_ff;
   entry_state_type   st_in;
   result_type        res_in;

   logic              out_valid_ff;
   result_type        out_ff;

   logic              advance;
   logic              take;

   mkte_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mkte_step u_step (
      .st      (st_ff),
      .cfg     (cfg),
      .key     (in_key_ff),
      .stamp   (in_time_ff),
      .st_next (st_in),
      .res     (res_in)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            st_ff        <= st_in;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_key_ff  <= req_if.key_code;
         in_time_ff <= req_if.press_time;
      end
      if (advance) begin
         out_ff <= res_in;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.action       = out_ff.action;
   assign rsp_if.position     = out_ff.position;
   assign rsp_if.out_char     = out_ff.out_char;
   assign rsp_if.entry_length = out_ff.entry_length;

endmodule

@@ src/mkte_csr.sv @@
module mkte_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mkte_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mkte_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output mkte_pkg::config_type              cfg
);
   import mkte_pkg::*;

   config_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_length   <= MAX_LENGTH_RESET;
         cfg_ff.switch_delay <= SWITCH_DELAY_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_LENGTH:   cfg_ff.max_length   <= csr_wdata[MAXLEN_W-1:0];
            CSR_SWITCH_DELAY: cfg_ff.switch_delay <= csr_wdata[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/mkte_step.sv @@
module mkte_step (
   input  mkte_pkg::entry_state_type         st,
   input  mkte_pkg::config_type              cfg,
   input  logic [mkte_pkg::KEY_W-1:0]        key,
   input  mkte_pkg::stamp_type               stamp,
   output mkte_pkg::entry_state_type         st_next,
   output mkte_pkg::result_type              res
);
   import mkte_pkg::*;

   logic                  digit;
   logic [DIGIT_W-1:0]    d;
   stamp_type             gap;
   logic                  repeat_hit;
   logic [TAP_W-1:0]      tap_new;
   logic [POS_W:0]        next_pos;

   always_comb begin
      digit      = (key >= KEY_ZERO) && (key <= KEY_NINE);
      d          = DIGIT_W'(key - KEY_ZERO);
      gap        = (st.prev_time >= stamp) ? st.prev_time - stamp : stamp - st.prev_time;
      repeat_hit = (st.prev_key == key) && (gap <= STAMP_BITS'(cfg.switch_delay));
      tap_new    = next_tap(st.tap_index, tap_count(d));
      next_pos   = {1'b0, st.cursor} + 1'b1;

      st_next = st;
      res     = '{action: ACT_NONE, position: '0, out_char: '0, entry_length: '0};

      if (!st.active) begin
         if (cfg.max_length <= MAXLEN_W'(1) || key == KEY_ENTER) begin
            res.action = ACT_FINISH;
         end else if (digit) begin
            st_next.active    = 1'b1;
            st_next.cursor    = '0;
            st_next.tap_index = '0;
            st_next.prev_key  = key;
            st_next.prev_time = stamp;
            res.action        = ACT_WRITE;
            res.out_char      = letter_at(d, '0);
         end
      end else if (key == KEY_ENTER) begin
         st_next.active   = 1'b0;
         res.action       = ACT_FINISH;
         res.position     = next_pos[POS_W-1:0];
         res.entry_length = next_pos[POS_W-1:0];
      end else if (key == KEY_CLEAR) begin
         st_next.prev_key  = key;
         st_next.prev_time = stamp;
         if (st.cursor != '0) begin
            res.action        = ACT_ERASE;
            res.position      = st.cursor;
            st_next.cursor    = st.cursor - 1'b1;
            st_next.tap_index = '0;
         end
      end else if (digit) begin
         st_next.prev_key  = key;
         st_next.prev_time = stamp;
         if (repeat_hit) begin
            st_next.tap_index = tap_new;
            res.action        = ACT_WRITE;
            res.position      = st.cursor;
            res.out_char      = letter_at(d, tap_new);
         end else if (next_pos + 1'b1 >= {1'b0, cfg.max_length}) begin
            // buffer full: the key that hits the limit is dropped
            st_next.active   = 1'b0;
            res.action       = ACT_FINISH;
            res.position     = next_pos[POS_W-1:0];
            res.entry_length = next_pos[POS_W-1:0];
         end else begin
            st_next.cursor    = next_pos[POS_W-1:0];
            st_next.tap_index = '0;
            res.action        = ACT_WRITE;
            res.position      = next_pos[POS_W-1:0];
            res.out_char      = letter_at(d, '0);
         end
      end
   end

endmodule
